>>> rtl/ordm_pkg.sv
package ordm_pkg;

  localparam int DISTINCT_ENTRIES = 64;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_DELETE = 3'd1;
  localparam logic [2:0] ACT_RANK   = 3'd2;
  localparam logic [2:0] ACT_KTH    = 3'd3;
  localparam logic [2:0] ACT_PRED   = 3'd4;
  localparam logic [2:0] ACT_SUCC   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  localparam logic [15:0] COPIES_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] key_value;
    logic [15:0]        order_index;
  } in_t;

  typedef struct packed {
    logic signed [31:0] answer_value;
    logic [16:0]        answer_rank;
    logic [1:0]         status;
  } out_t;

  // what a cell shows its neighbours and the top level
  typedef struct packed {
    logic        occ;
    logic        lt;
    logic        eq;
    logic [31:0] value;
    logic [15:0] copies;
    logic [15:0] below;
  } cell_t;

  // update broadcast to every cell
  typedef struct packed {
    logic        ins_new;
    logic        ins_hit;
    logic        del_dec;
    logic        del_rm;
    logic [31:0] key;
  } ctrl_t;

endpackage

>>> rtl/ordm_cell.sv
module ordm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ordm_pkg::ctrl_t ctrl_i,
  input  ordm_pkg::cell_t left_i,
  input  ordm_pkg::cell_t right_i,
  output ordm_pkg::cell_t cell_o
);

  logic [31:0] value_q, value_d;
  logic [15:0] copies_q, copies_d;
  logic [15:0] below_q, below_d;
  logic        occ, lt, eq, is_pos;

  assign occ    = (copies_q != 16'd0);
  assign lt     = occ && ($signed(value_q) < $signed(ctrl_i.key));
  assign eq     = occ && (value_q == ctrl_i.key);
  assign is_pos = !lt && left_i.lt;

  always_comb begin
    value_d  = value_q;
    copies_d = copies_q;
    below_d  = below_q;
    if (ctrl_i.ins_new && !lt) begin
      if (is_pos) begin
        value_d  = ctrl_i.key;
        copies_d = 16'd1;
        below_d  = left_i.below + left_i.copies;
      end else begin
        value_d  = left_i.value;
        copies_d = left_i.copies;
        below_d  = left_i.below + 16'd1;
      end
    end else if (ctrl_i.ins_hit) begin
      if (eq) begin
        copies_d = copies_q + 16'd1;
      end else if (!lt) begin
        below_d = below_q + 16'd1;
      end
    end else if (ctrl_i.del_dec) begin
      if (eq) begin
        copies_d = copies_q - 16'd1;
      end else if (!lt) begin
        below_d = below_q - 16'd1;
      end
    end else if (ctrl_i.del_rm && !lt) begin
      value_d  = right_i.value;
      copies_d = right_i.copies;
      below_d  = right_i.below - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copies_q <= '0;
      below_q  <= '0;
    end else begin
      copies_q <= copies_d;
      below_q  <= below_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = '{occ: occ, lt: lt, eq: eq, value: value_q,
                    copies: copies_q, below: below_q};

endmodule

>>> rtl/order_statistic_multiset.sv
// Ordered multiset of signed 32-bit values held as a sorted row of cells, one distinct
// value and its copy count per cell, plus a running count of the copies stored below it.
// Every input beat yields exactly one output beat. An item is registered on acceptance,
// then in the next cycle every cell compares its value with the key at once, the answer
// is picked from the cell flagged by the compare and registered, and inserts of a new
// value and deletes of a last copy shift the row one place through neighbour links in
// that same cycle. A new item is taken at the edge after its predecessor's result is
// registered, provided that result drains then, so the block takes no new item before
// the result of the last one is registered.
module order_statistic_multiset #(
  parameter int DistinctEntries = ordm_pkg::DISTINCT_ENTRIES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ordm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ordm_pkg::out_t out_data_o
);

  // request register and execute flag
  logic          busy_q;
  ordm_pkg::in_t req_q;
  logic          in_acc;

  // output register
  logic           out_valid_q;
  ordm_pkg::out_t out_q, out_d;

  logic [15:0] total_q, total_d;

  ordm_pkg::ctrl_t ctrl;
  ordm_pkg::cell_t cells [DistinctEntries];
  ordm_pkg::cell_t edge_left, edge_right;
  logic [DistinctEntries-1:0] occ_vec;

  // cell zero sees a left neighbour below every key; the last cell sees an empty right one
  assign edge_left  = '{occ: 1'b1, lt: 1'b1, eq: 1'b0, value: '0, copies: '0, below: '0};
  assign edge_right = '0;

  for (genvar g = 0; g < DistinctEntries; g++) begin : g_cell
    ordm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i ((g == 0) ? edge_left : cells[(g == 0) ? 0 : g-1]),
      .right_i((g == DistinctEntries-1) ? edge_right
                                        : cells[(g == DistinctEntries-1) ? g : g+1]),
      .cell_o (cells[g])
    );
    assign occ_vec[g] = cells[g].occ;
  end

  // handshake: take a beat while idle, provided the output slot is free or drains now
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // per-cell flags reduced by wide or over independent cells
  logic        hit, full, pos_occ;
  logic [15:0] hit_copies, pos_below;
  logic [31:0] kth_val, pred_val, succ_val;
  logic        kth_any, pred_any, succ_any;
  logic [16:0] kk, lo, hi;

  always_comb begin
    hit = 1'b0; pos_occ = 1'b0; hit_copies = '0; pos_below = '0;
    kth_val = '0; pred_val = '0; succ_val = '0;
    kth_any = 1'b0; pred_any = 1'b0; succ_any = 1'b0;
    kk = {1'b0, req_q.order_index};
    lo = '0; hi = '0;
    for (int i = 0; i < DistinctEntries; i++) begin
      lo = {1'b0, cells[i].below};
      hi = {1'b0, cells[i].below} + {1'b0, cells[i].copies};
      if (cells[i].eq) begin
        hit        = 1'b1;
        hit_copies = hit_copies | cells[i].copies;
      end
      // first cell not below the key
      if (!cells[i].lt && ((i == 0) || cells[(i == 0) ? 0 : i-1].lt) && cells[i].occ) begin
        pos_occ   = 1'b1;
        pos_below = pos_below | cells[i].below;
      end
      if (cells[i].occ && (kk > lo) && (kk <= hi)) begin
        kth_any = 1'b1;
        kth_val = kth_val | cells[i].value;
      end
      // last cell below the key
      if (cells[i].lt && ((i == DistinctEntries-1) ||
          !cells[(i == DistinctEntries-1) ? i : i+1].lt)) begin
        pred_any = 1'b1;
        pred_val = pred_val | cells[i].value;
      end
      // first cell above the key
      if (cells[i].occ && !cells[i].lt && !cells[i].eq &&
          ((i == 0) || cells[(i == 0) ? 0 : i-1].lt || cells[(i == 0) ? 0 : i-1].eq)) begin
        succ_any = 1'b1;
        succ_val = succ_val | cells[i].value;
      end
    end
    full = occ_vec[DistinctEntries-1];
  end

  // execute cycle: decode the request, drive the cells, form the answer
  always_comb begin
    ctrl         = '0;
    ctrl.key     = req_q.key_value;
    total_d      = total_q;
    out_d        = '0;
    out_d.status = ordm_pkg::ST_OK;
    case (req_q.action)
      ordm_pkg::ACT_INSERT: begin
        if ((total_q == ordm_pkg::COPIES_MAX) || (!hit && full)) begin
          out_d.status = ordm_pkg::ST_FULL;
        end else begin
          ctrl.ins_hit = busy_q && hit;
          ctrl.ins_new = busy_q && !hit;
          total_d      = total_q + 16'd1;
        end
      end
      ordm_pkg::ACT_DELETE: begin
        if (!hit) begin
          out_d.status = ordm_pkg::ST_ABSENT;
        end else begin
          ctrl.del_rm  = busy_q && (hit_copies == 16'd1);
          ctrl.del_dec = busy_q && (hit_copies != 16'd1);
          total_d      = total_q - 16'd1;
        end
      end
      ordm_pkg::ACT_RANK: begin
        out_d.answer_rank = pos_occ ? ({1'b0, pos_below} + 17'd1)
                                    : ({1'b0, total_q} + 17'd1);
      end
      ordm_pkg::ACT_KTH: begin
        if ((req_q.order_index == 16'd0) || (req_q.order_index > total_q) || !kth_any) begin
          out_d.status = ordm_pkg::ST_NONE;
        end else begin
          out_d.answer_value = kth_val;
        end
      end
      ordm_pkg::ACT_PRED: begin
        if (pred_any) out_d.answer_value = pred_val;
        else          out_d.status = ordm_pkg::ST_NONE;
      end
      ordm_pkg::ACT_SUCC: begin
        if (succ_any) out_d.answer_value = succ_val;
        else          out_d.status = ordm_pkg::ST_NONE;
      end
      default: begin
        out_d.status = ordm_pkg::ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      busy_q <= in_acc;
      if (busy_q) begin
        out_valid_q <= 1'b1;
        total_q     <= total_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_data_i;
    if (busy_q) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the output slot is always free while an item executes
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !out_valid_q)
    else $error("execute cycle with output slot occupied");

  // every executing item leaves a valid result in the output register in the cycle after
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |=> out_valid_q)
    else $error("result missing after execute");

  // occupied cells form a prefix of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_vec[DistinctEntries-1:1] & ~occ_vec[DistinctEntries-2:0]) == '0)
    else $error("gap in occupied cells");

  // an empty set has no occupied cell
  assert property (@(posedge clk_i) disable iff (!rst_ni) (total_q == 16'd0) |-> (occ_vec == '0))
    else $error("cells occupied with zero total");

endmodule

>>> tb/multiset_checker.sv
module multiset_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  ordm_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  ordm_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  logic [31:0]    held_value [ordm_pkg::DISTINCT_ENTRIES];
  logic [15:0]    held_copies [ordm_pkg::DISTINCT_ENTRIES];
  logic [15:0]    held_total;
  int             held_used;
  ordm_pkg::out_t answers_due [$];

  function automatic logic [31:0] flip(logic [31:0] v);
    return v ^ 32'h8000_0000;
  endfunction

  // apply one beat to the shadow multiset and return the answer it should give
  function automatic ordm_pkg::out_t apply_beat(ordm_pkg::in_t b);
    ordm_pkg::out_t r;
    int             pos;
    bit             hit;
    logic [16:0]    acc;
    r = '0;
    pos = 0;
    while (pos < held_used && flip(held_value[pos]) < flip(b.key_value)) pos++;
    hit = pos < held_used && held_value[pos] == b.key_value;
    case (b.action)
      ordm_pkg::ACT_INSERT: begin
        if (held_total == ordm_pkg::COPIES_MAX) r.status = ordm_pkg::ST_FULL;
        else if (hit) begin
          held_copies[pos]++;
          held_total++;
        end else if (held_used >= ordm_pkg::DISTINCT_ENTRIES) r.status = ordm_pkg::ST_FULL;
        else begin
          for (int i = held_used; i > pos; i--) begin
            held_value[i] = held_value[i-1];
            held_copies[i] = held_copies[i-1];
          end
          held_value[pos] = b.key_value;
          held_copies[pos] = 16'd1;
          held_total++;
          held_used++;
        end
      end
      ordm_pkg::ACT_DELETE: begin
        if (!hit) r.status = ordm_pkg::ST_ABSENT;
        else begin
          held_copies[pos]--;
          held_total--;
          if (held_copies[pos] == 0) begin
            for (int i = pos; i + 1 < held_used; i++) begin
              held_value[i] = held_value[i+1];
              held_copies[i] = held_copies[i+1];
            end
            held_used--;
          end
        end
      end
      ordm_pkg::ACT_RANK: begin
        acc = 17'd1;
        for (int i = 0; i < pos; i++) acc += held_copies[i];
        r.answer_rank = acc;
      end
      ordm_pkg::ACT_KTH: begin
        if (b.order_index == 0 || b.order_index > held_total) r.status = ordm_pkg::ST_NONE;
        else begin
          acc = '0;
          for (int i = 0; i < held_used; i++) begin
            acc += held_copies[i];
            if (acc >= b.order_index) begin
              r.answer_value = held_value[i];
              break;
            end
          end
        end
      end
      ordm_pkg::ACT_PRED: begin
        if (pos == 0) r.status = ordm_pkg::ST_NONE;
        else r.answer_value = held_value[pos-1];
      end
      ordm_pkg::ACT_SUCC: begin
        if (hit) pos++;
        if (pos >= held_used) r.status = ordm_pkg::ST_NONE;
        else r.answer_value = held_value[pos];
      end
      default: r.status = ordm_pkg::ST_NONE;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ordm_pkg::out_t want;
    int             errs;
    errs = 0;
    if (!rst_ni) begin
      held_total = '0;
      held_used = 0;
      fail_count_o <= 0;
      answers_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) answers_due.push_back(apply_beat(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          $error("result beat with nothing expected");
          errs++;
        end else begin
          want = answers_due.pop_front();
          if (out_data_i.answer_value !== want.answer_value) begin
            $error("answer_value expected %0d got %0d", want.answer_value,
                   out_data_i.answer_value);
            errs++;
          end
          if (out_data_i.answer_rank !== want.answer_rank) begin
            $error("answer_rank expected %0d got %0d", want.answer_rank,
                   out_data_i.answer_rank);
            errs++;
          end
          if (out_data_i.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_data_i.status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

  assign pending_o = answers_due.size();

endmodule

>>> tb/testbench.sv
module testbench;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  ordm_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  ordm_pkg::out_t out_data;
  int             fail_count;
  int             pending;
  bit             long_hold;  // receiver holds off for a long stretch
  bit             hold_done;

  // small pool of values so that duplicates, hits and deletes happen often
  logic signed [31:0] value_pool [24];

  order_statistic_multiset i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  multiset_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one beat after a random gap, hold it until taken
  task automatic send_beat(logic [2:0] act, logic signed [31:0] key, logic [15:0] k);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, key_value: key, order_index: k};
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return value_pool[$urandom_range(0, 23)];
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int wait_cycles;
    out_stall <= 1'b1;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_done = 1'b1;
      end
      wait_cycles = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) wait_cycles = 0;
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles - 1) @(posedge clk);
      end else out_stall <= 1'b0;
      if (wait_cycles > 0) begin
        @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int                 lap;
    logic [2:0]         act;
    logic signed [31:0] key;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    long_hold = 1'b0;
    foreach (value_pool[i]) value_pool[i] = $urandom_range(0, 3) == 0 ? $urandom
                                             : $signed($urandom_range(0, 60)) - 30;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queries, extremes, duplicates, absent delete, unused actions
    send_beat(ordm_pkg::ACT_PRED, 0, 16'd0);
    send_beat(ordm_pkg::ACT_SUCC, 0, 16'd0);
    send_beat(ordm_pkg::ACT_KTH, 0, 16'd1);
    send_beat(ordm_pkg::ACT_DELETE, 5, 16'd0);
    send_beat(ordm_pkg::ACT_RANK, 32'sh7FFF_FFFF, 16'd0);
    send_beat(ordm_pkg::ACT_INSERT, 32'sh8000_0000, 16'd0);
    send_beat(ordm_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 16'd0);
    send_beat(ordm_pkg::ACT_INSERT, 0, 16'd0);
    send_beat(ordm_pkg::ACT_INSERT, 0, 16'd0);
    send_beat(ordm_pkg::ACT_INSERT, -1, 16'd0);
    send_beat(ordm_pkg::ACT_RANK, 1, 16'd0);
    send_beat(ordm_pkg::ACT_RANK, 0, 16'd0);
    send_beat(ordm_pkg::ACT_KTH, 0, 16'd0);
    send_beat(ordm_pkg::ACT_KTH, 0, 16'd3);
    send_beat(ordm_pkg::ACT_KTH, 0, 16'd6);
    send_beat(ordm_pkg::ACT_KTH, 0, 16'hFFFF);
    send_beat(ordm_pkg::ACT_PRED, 32'sh8000_0000, 16'd0);
    send_beat(ordm_pkg::ACT_SUCC, 32'sh7FFF_FFFF, 16'd0);
    send_beat(ordm_pkg::ACT_PRED, 0, 16'd0);
    send_beat(ordm_pkg::ACT_SUCC, 0, 16'd0);
    send_beat(ordm_pkg::ACT_DELETE, 0, 16'd0);
    send_beat(ordm_pkg::ACT_DELETE, 32'sh8000_0000, 16'd0);
    send_beat(3'd6, $urandom, 16'($urandom));
    send_beat(3'd7, $urandom, 16'($urandom));

    // fill the table past its distinct limit to hit the full case, drain, then delete all again
    for (int i = 0; i < ordm_pkg::DISTINCT_ENTRIES + 4; i++)
      send_beat(ordm_pkg::ACT_INSERT, 1000 + i * 7, 16'd0);
    drain();
    long_hold = 1'b1;
    for (int i = 0; i < ordm_pkg::DISTINCT_ENTRIES + 4; i++)
      send_beat(ordm_pkg::ACT_DELETE, 1000 + i * 7, 16'd0);
    drain();

    // random: insert-heavy and delete-heavy laps so the size swings both ways
    for (int n = 0; n < 1650; n++) begin
      lap = (n / 300) % 2;
      case ($urandom_range(0, 9))
        0, 1, 2: act = lap ? ordm_pkg::ACT_DELETE : ordm_pkg::ACT_INSERT;
        3:       act = lap ? ordm_pkg::ACT_INSERT : ordm_pkg::ACT_DELETE;
        4:       act = ordm_pkg::ACT_RANK;
        5, 6:    act = ordm_pkg::ACT_KTH;
        7:       act = ordm_pkg::ACT_PRED;
        8:       act = ordm_pkg::ACT_SUCC;
        default: act = 3'($urandom_range(0, 7));
      endcase
      key = pick_key();
      send_beat(act, key, ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 80)));
      if (n == 900) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
